// File: design/lane_parallel_xoshiro_range_draw_macros.svh
// Assertion helpers used by the block's top module.
`ifndef LANE_PARALLEL_XOSHIRO_RANGE_DRAW_MACROS_SVH
`define LANE_PARALLEL_XOSHIRO_RANGE_DRAW_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPXRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPXRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/lpxrd_pkg.sv
package lpxrd_pkg;

	localparam int LANES_DEFAULT = 4;
	localparam int LANE_W        = 4;
	localparam int SEED_W        = 64;
	localparam int MAX_W         = 32;
	localparam int VALUE_W       = 32;
	localparam int WORD_W        = 32;
	localparam int SHIFT_K       = 17;
	localparam int ROT_K         = 45;

	localparam logic OP_DRAW  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [1:0] {
		SEL_A = 2'd0,
		SEL_B = 2'd1,
		SEL_C = 2'd2,
		SEL_D = 2'd3
	} word_sel_t;

	typedef struct packed {
		logic              write;
		logic              advance;
		word_sel_t         word_select;
		logic [SEED_W-1:0] seed_word;
	} lane_ctrl_t;

endpackage

// File: design/lpxrd_lane.sv
module lpxrd_lane import lpxrd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  lane_ctrl_t        ctrl,
	output logic [SEED_W-1:0] sum
);

	logic [SEED_W-1:0] s0_q, s1_q, s2_q, s3_q;
	logic [SEED_W-1:0] t, c1, d1, b1, a1, c2, d2;

	// One xoshiro256+ step, written out in the order of the usual algorithm.
	always_comb begin
		t  = s1_q << SHIFT_K;
		c1 = s2_q ^ s0_q;
		d1 = s3_q ^ s1_q;
		b1 = s1_q ^ c1;
		a1 = s0_q ^ d1;
		c2 = c1 ^ t;
		d2 = {d1[SEED_W-1-ROT_K:0], d1[SEED_W-1:SEED_W-ROT_K]};
	end

	assign sum = s0_q + s3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_q <= '0;
			s1_q <= '0;
			s2_q <= '0;
			s3_q <= '0;
		end else if (ctrl.advance) begin
			s0_q <= a1;
			s1_q <= b1;
			s2_q <= c2;
			s3_q <= d2;
		end else if (ctrl.write) begin
			unique case (ctrl.word_select)
				SEL_A: s0_q <= ctrl.seed_word;
				SEL_B: s1_q <= ctrl.seed_word;
				SEL_C: s2_q <= ctrl.seed_word;
				SEL_D: s3_q <= ctrl.seed_word;
				default: s3_q <= ctrl.seed_word;
			endcase
		end
	end

endmodule

// File: design/lpxrd_scale.sv
module lpxrd_scale import lpxrd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [WORD_W-1:0]  word,
	input  logic [MAX_W-1:0]   max,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [VALUE_W-1:0] value
);

	logic [WORD_W+MAX_W-1:0] product;
	logic                    valid_q;
	logic [VALUE_W-1:0]      value_q;

	assign product = {{MAX_W{1'b0}}, word} * {{WORD_W{1'b0}}, max};

	// The high half is below max unless max is zero, so adding one cannot wrap.
	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= product[WORD_W+MAX_W-1:WORD_W] + VALUE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign value     = value_q;

endmodule

// File: design/lane_parallel_xoshiro_range_draw.sv
// Channel | Direction | Handshake            | Fields
// in      | input     | in_valid / in_ready  | op, max, lane, word_select, seed_word
// out     | output    | out_valid / out_ready| value
//
// An accepted item is registered; a write updates one lane's state in the next cycle and a draw
// multiplies the buffered word by max into the output register, refilling if needed.
// A draw goes via the input and output registers; one item per cycle unless a draw waits.
// Reset clears all generator state and the word buffer and parks the pointer on the last word.
// A draw waits in the input register while the output register holds an untaken value;
// writes pass through regardless of the output side.
`include "lane_parallel_xoshiro_range_draw_macros.svh"

module lane_parallel_xoshiro_range_draw import lpxrd_pkg::*; #(
	parameter int LANES = LANES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [MAX_W-1:0]   max,
	input  logic [LANE_W-1:0]  lane,
	input  logic [1:0]         word_select,
	input  logic [SEED_W-1:0]  seed_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VALUE_W-1:0] value
);

	localparam int BUF_WORDS = 2 * LANES;
	localparam int PTR_W     = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(BUF_WORDS - 1);

	logic               valid_s1;
	logic               op_s1;
	logic [MAX_W-1:0]   max_s1;
	logic [LANE_W-1:0]  lane_s1;
	logic [1:0]         sel_s1;
	logic [SEED_W-1:0]  seed_s1;

	logic [PTR_W-1:0]   ptr_q;
	logic [WORD_W-1:0]  buf_q [BUF_WORDS];
	logic [SEED_W-1:0]  lane_sum [LANES];

	logic in_fire, s1_done, draw_fire, write_fire, refill;

	assign in_fire    = in_valid && in_ready;
	assign s1_done    = valid_s1 && (op_s1 == OP_WRITE || !out_valid || out_ready);
	assign in_ready   = !valid_s1 || s1_done;
	assign draw_fire  = s1_done && op_s1 == OP_DRAW;
	assign write_fire = s1_done && op_s1 == OP_WRITE;
	assign refill     = draw_fire && ptr_q >= LAST_PTR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= op;
			max_s1  <= max;
			lane_s1 <= lane;
			sel_s1  <= word_select;
			seed_s1 <= seed_word;
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		lane_ctrl_t ctrl;

		always_comb begin
			ctrl.write       = write_fire && lane_s1 == LANE_W'(k);
			ctrl.advance     = refill;
			ctrl.word_select = word_sel_t'(sel_s1);
			ctrl.seed_word   = seed_s1;
		end

		lpxrd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sum    (lane_sum[k])
		);

		// The refill stores each lane's sum before the step, low half first.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				buf_q[2*k]   <= '0;
				buf_q[2*k+1] <= '0;
			end else if (refill) begin
				buf_q[2*k]   <= lane_sum[k][WORD_W-1:0];
				buf_q[2*k+1] <= lane_sum[k][SEED_W-1:WORD_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= LAST_PTR;
		end else if (refill) begin
			ptr_q <= '0;
		end else if (draw_fire) begin
			ptr_q <= ptr_q + PTR_W'(1);
		end
	end

	lpxrd_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (draw_fire),
		.word      (buf_q[ptr_q]),
		.max       (max_s1),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.value     (value)
	);

	`LPXRD_ASSERT_NEXT(a_wrap_to_zero, clk, arst_n, refill, ptr_q == '0, "pointer did not wrap")
	`LPXRD_ASSERT_NEXT(a_ptr_step, clk, arst_n, draw_fire && !refill,
		ptr_q == $past(ptr_q) + PTR_W'(1), "pointer did not step")
	`LPXRD_ASSERT_NEXT(a_draw_gives_value, clk, arst_n, draw_fire, out_valid,
		"draw gave no value")
	`LPXRD_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid && !out_ready, !draw_fire,
		"held value overwritten")
	`LPXRD_ASSERT_NOW(a_ptr_range, clk, arst_n, 1'b1, ptr_q <= LAST_PTR,
		"pointer beyond buffer")

endmodule

// File: verif/tb_lane_parallel_xoshiro_range_draw.sv
module tb_lane_parallel_xoshiro_range_draw;
	import lpxrd_pkg::*;

	localparam int LANES        = LANES_DEFAULT;
	localparam int WORDS        = 2 * LANES;
	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 300;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic               op;
		logic [MAX_W-1:0]   max;
		logic [LANE_W-1:0]  lane;
		word_sel_t          sel;
		logic [SEED_W-1:0]  seed;
		bit                 typed;
		logic [VALUE_W-1:0] want;
	} stim_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = OP_DRAW;
	logic [MAX_W-1:0]   max = '0;
	logic [LANE_W-1:0]  lane = '0;
	word_sel_t          word_select = SEL_A;
	logic [SEED_W-1:0]  seed_word = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [VALUE_W-1:0] value;

	// Predicted generator state, one set of four words per lane.
	logic [SEED_W-1:0]  gen_s0 [LANES];
	logic [SEED_W-1:0]  gen_s1 [LANES];
	logic [SEED_W-1:0]  gen_s2 [LANES];
	logic [SEED_W-1:0]  gen_s3 [LANES];
	logic [WORD_W-1:0]  draw_words [WORDS];
	int unsigned        draw_ptr;

	logic [VALUE_W-1:0] pending_values [$];
	int                 mismatches = 0;
	int                 values_seen = 0;
	int                 idle_cycles = 0;
	bit                 tx_steady = 1'b0;

	lane_parallel_xoshiro_range_draw #(
		.LANES(LANES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.max(max),
		.lane(lane),
		.word_select(word_select),
		.seed_word(seed_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_generators();
		for (int k = 0; k < LANES; k++) begin
			gen_s0[k] = '0;
			gen_s1[k] = '0;
			gen_s2[k] = '0;
			gen_s3[k] = '0;
		end
		for (int w = 0; w < WORDS; w++) begin
			draw_words[w] = '0;
		end
		draw_ptr = WORDS - 1;
	endfunction

	// Every lane contributes its pre-advance s0+s3, low half first, then steps once.
	function automatic void refill_words();
		logic [SEED_W-1:0] total;
		logic [SEED_W-1:0] shifted;
		for (int k = 0; k < LANES; k++) begin
			total = gen_s0[k] + gen_s3[k];
			shifted = gen_s1[k] << SHIFT_K;
			draw_words[2 * k] = total[31:0];
			draw_words[2 * k + 1] = total[63:32];
			gen_s2[k] ^= gen_s0[k];
			gen_s3[k] ^= gen_s1[k];
			gen_s1[k] ^= gen_s2[k];
			gen_s0[k] ^= gen_s3[k];
			gen_s2[k] ^= shifted;
			gen_s3[k] = (gen_s3[k] << ROT_K) | (gen_s3[k] >> (SEED_W - ROT_K));
		end
	endfunction

	// Applies one accepted item; returns 1 with the scaled value when it is a draw.
	function automatic bit predict_value(input stim_t s, output logic [VALUE_W-1:0] v);
		logic [WORD_W-1:0]        w;
		logic [WORD_W+MAX_W-1:0]  product;
		v = '0;
		if (s.op == OP_WRITE) begin
			if (int'(s.lane) < LANES) begin
				case (s.sel)
					SEL_A: gen_s0[s.lane] = s.seed;
					SEL_B: gen_s1[s.lane] = s.seed;
					SEL_C: gen_s2[s.lane] = s.seed;
					default: gen_s3[s.lane] = s.seed;
				endcase
			end
			return 1'b0;
		end
		if (draw_ptr >= WORDS - 1) begin
			w = draw_words[WORDS - 1];
			draw_ptr = 0;
			refill_words();
		end else begin
			w = draw_words[draw_ptr];
			draw_ptr++;
		end
		product = 64'(w) * 64'(s.max);
		v = product[63:32] + 32'd1;
		return 1'b1;
	endfunction

	function automatic void flag_error(input string msg);
		if (mismatches < MAX_REPORTS) begin
			$display("%s", msg);
		end
		mismatches++;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SEED_W-1:0] rand_seed();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [MAX_W-1:0] rand_max();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'd1;
			3: return 32'd32767;
			default: return $urandom;
		endcase
	endfunction

	// Fields that a draw ignores are filled at random.
	function automatic stim_t draw_row(input logic [MAX_W-1:0] m, input bit typed,
			input logic [VALUE_W-1:0] want);
		stim_t s;
		s.op = OP_DRAW;
		s.max = m;
		s.lane = LANE_W'($urandom);
		s.sel = word_sel_t'($urandom_range(SEL_A, SEL_D));
		s.seed = {$urandom, $urandom};
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	function automatic stim_t write_row(input logic [LANE_W-1:0] ln, input word_sel_t sel,
			input logic [SEED_W-1:0] seed);
		stim_t s;
		s.op = OP_WRITE;
		s.max = $urandom;
		s.lane = ln;
		s.sel = sel;
		s.seed = seed;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	task automatic offer_item(input stim_t s);
		int gap;
		logic [VALUE_W-1:0] v;
		gap = tx_steady ? 0 : idle_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= s.op;
		max <= s.max;
		lane <= s.lane;
		word_select <= s.sel;
		seed_word <= s.seed;
		do @(posedge clk); while (!in_ready);
		if (predict_value(s, v)) begin
			pending_values.push_back(s.typed ? s.want : v);
		end
	endtask

	always @(posedge clk) begin
		logic [VALUE_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			values_seen++;
			if (pending_values.size() == 0) begin
				flag_error($sformatf("value %h arrived with nothing expected", value));
			end else begin
				want = pending_values.pop_front();
				if (value !== want) begin
					flag_error($sformatf("value mismatch: expected %h, got %h", want, value));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("tb_lane_parallel_xoshiro_range_draw: done, errors");
			$finish;
		end
	end

	initial begin
		int stall;
		bit held;
		bit steady;
		held = 1'b0;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && values_seen >= HOLD_AFTER) begin
				// A long hold lets the output register fill so that draws back up at the input.
				held = 1'b1;
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end
			if ($urandom_range(0, 63) == 0) steady = !steady;
			stall = steady ? 0 : idle_gap();
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
		end
	end

	initial begin
		stim_t rows [$];
		int counted;
		int pick;
		logic [LANE_W-1:0] ln;
		bit blank;
		clear_generators();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// From reset the pointer sits on the last word and every generator is zero.
		rows.push_back(draw_row('0, 1'b1, 32'd1));
		rows.push_back(draw_row('1, 1'b1, 32'd1));
		rows.push_back(write_row(4'hf, SEL_D, '1));
		rows.push_back(write_row(LANE_W'(0), SEL_A, 64'd1));
		rows.push_back(write_row(LANE_W'(0), SEL_D, '1));
		rows.push_back(write_row(LANE_W'(1), SEL_A, 64'h0123_4567_89ab_cdef));
		rows.push_back(write_row(LANE_W'(1), SEL_B, 64'hfedc_ba98_7654_3210));
		rows.push_back(write_row(LANE_W'(2), SEL_C, 64'h8000_0000_0000_0000));
		rows.push_back(write_row(LANE_W'(LANES - 1), SEL_B, 64'h5555_5555_5555_5555));
		rows.push_back(write_row(LANE_W'(LANES - 1), SEL_D, 64'hffff_ffff_0000_0000));
		// The discard draw and the rest of the buffer still read zeros; the last one refills.
		rows.push_back(draw_row(32'd32767, 1'b1, 32'd1));
		for (int i = 0; i < WORDS - 2; i++) begin
			rows.push_back(draw_row((i % 2) ? '1 : $urandom, 1'b1, 32'd1));
		end
		rows.push_back(draw_row('1, 1'b0, '0));
		rows.push_back(draw_row('0, 1'b1, 32'd1));
		rows.push_back(draw_row(32'd1, 1'b1, 32'd1));
		rows.push_back(draw_row(32'd32767, 1'b0, '0));
		rows.push_back(draw_row(32'h8000_0000, 1'b0, '0));
		rows.push_back(draw_row(32'h5555_5555, 1'b0, '0));
		rows.push_back(draw_row(32'haaaa_aaaa, 1'b0, '0));
		foreach (rows[i]) begin
			offer_item(rows[i]);
		end

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				// Full reseed followed by the discard draw; now and then a lane is left at zero.
				for (int k = 0; k < LANES; k++) begin
					blank = ($urandom_range(0, 9) == 0);
					for (int w = SEL_A; w <= SEL_D; w++) begin
						offer_item(write_row(LANE_W'(k), word_sel_t'(w),
							blank ? 64'd0 : rand_seed()));
					end
				end
				offer_item(draw_row(32'd32767, 1'b0, '0));
				counted += 4 * LANES + 1;
			end else if (pick < 15) begin
				ln = LANE_W'($urandom);
				offer_item(write_row(ln, word_sel_t'($urandom_range(SEL_A, SEL_D)),
					rand_seed()));
				counted++;
			end else begin
				offer_item(draw_row(rand_max(), 1'b0, '0));
				counted++;
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_lane_parallel_xoshiro_range_draw: done, clean");
		end else begin
			$display("tb_lane_parallel_xoshiro_range_draw: done, errors");
		end
		$finish;
	end

endmodule
